FILE: rtl/acm_pkg.sv
// Shared types and constants for the affine cipher core.
package acm_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_MODULUS    = 2'd0;
  localparam logic [1:0] REG_MULTIPLIER = 2'd1;
  localparam logic [1:0] REG_OFFSET     = 2'd2;
  localparam logic [1:0] REG_DECRYPT    = 2'd3;

  // Key and modulus width, and the modular adder width (room for m + ~b wrap)
  localparam int KEY_W  = 8;
  localparam int UNIT_W = 10;

  // Live configuration seen by the sequencer
  typedef struct packed {
    logic [KEY_W-1:0] modulus;
    logic [KEY_W-1:0] multiplier;
    logic [KEY_W-1:0] offset;
    logic             decrypt_mode;
  } cfg_t;

  // Result handed from the sequencer to the top level
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] sym;
    logic             err;
  } res_t;

endpackage

FILE: rtl/affine_cipher_mod_m_core.sv
// Offset and symbol are reduced; encrypt then multiplies by the multiplier and adds the offset,
// decrypt subtracts the offset and multiplies by the inverse. A modulus or multiplier change makes
// the next symbol reduce the multiplier and search its inverse, then cache the key result. A cached
// bad key or modulus zero answers from idle; busy ignores start. The adder is used once per cycle.
// Reset (rst, synchronous) loads modulus 26, multiplier 1, offset 0, encrypt, clears the key cache.
// done is a one-cycle strobe; the receiver cannot stall it.
module affine_cipher_mod_m_core #(
  parameter int SYMBOL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [SYMBOL_BITS-1:0]    symbol_in,
  output logic                      done,
  output logic [SYMBOL_BITS-1:0]    symbol_out,
  output logic                      key_error,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [acm_pkg::KEY_W-1:0] cfg_data
);
  import acm_pkg::*;

  localparam int SHW = (SYMBOL_BITS > KEY_W) ? SYMBOL_BITS : KEY_W;

  cfg_t          cfg;
  res_t          res;
  logic          key_flush;
  logic          cfg_wr;
  logic [SHW-1:0] sym_ext;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign key_flush = cfg_wr && (cfg_index == REG_MODULUS || cfg_index == REG_MULTIPLIER);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus      <= KEY_W'(26);
      cfg.multiplier   <= KEY_W'(1);
      cfg.offset       <= '0;
      cfg.decrypt_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_MODULUS:    cfg.modulus      <= cfg_data;
        REG_MULTIPLIER: cfg.multiplier   <= cfg_data;
        REG_OFFSET:     cfg.offset       <= cfg_data;
        REG_DECRYPT:    cfg.decrypt_mode <= cfg_data[0];
        default:        cfg.offset       <= cfg.offset;
      endcase
    end
  end

  acm_seq #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .symbol_in (symbol_in),
    .cfg       (cfg),
    .key_flush (key_flush),
    .busy      (busy),
    .res       (res)
  );

  // Fit the 8-bit residue to the symbol width
  assign sym_ext    = SHW'(res.sym);
  assign done       = res.valid;
  assign symbol_out = sym_ext[SYMBOL_BITS-1:0];
  assign key_error  = res.err;

  // Strobe only while idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted symbol either starts work or answers at once
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted symbol dropped");

  // Key error carries symbol zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && key_error) |-> (symbol_out == '0))
    else $error("nonzero symbol on key error");

  // Modulus zero always reports a key error
  a_mod_zero: assert property (@(posedge clk) disable iff (rst)
    (done && cfg.modulus == '0) |-> key_error)
    else $error("modulus zero without key error");

endmodule

FILE: rtl/acm_modadd.sv
// Shared modular adder: (a + b + cin) reduced once against the modulus.
module acm_modadd (
  input  logic [acm_pkg::UNIT_W-1:0] a,
  input  logic [acm_pkg::UNIT_W-1:0] b,
  input  logic                       cin,
  input  logic [acm_pkg::KEY_W-1:0]  modulus,
  output logic [acm_pkg::UNIT_W-1:0] sum
);
  import acm_pkg::*;

  logic [UNIT_W-1:0] raw;
  logic [UNIT_W-1:0] m_ext;

  // Raw sum wraps at UNIT_W bits so that m + ~b + 1 gives m - b
  assign raw   = a + b + UNIT_W'(cin);
  assign m_ext = UNIT_W'(modulus);

  // One conditional subtract; callers keep raw below twice the modulus
  assign sum = (raw >= m_ext) ? (raw - m_ext) : raw;

endmodule

FILE: rtl/acm_seq.sv
// Sequencer: key reduction, inverse search, offset and symbol reduction, modular multiply and offset add or subtract.
module acm_seq #(
  parameter int SYMBOL_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SYMBOL_BITS-1:0] symbol_in,
  input  acm_pkg::cfg_t          cfg,
  input  logic                   key_flush,
  output logic                   busy,
  output acm_pkg::res_t          res
);
  import acm_pkg::*;

  localparam int SHW = (SYMBOL_BITS > KEY_W) ? SYMBOL_BITS : KEY_W;
  localparam int CW  = $clog2(SHW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ARED = 4'd1;
  localparam logic [3:0] S_INV  = 4'd2;
  localparam logic [3:0] S_BRED = 4'd3;
  localparam logic [3:0] S_XRED = 4'd4;
  localparam logic [3:0] S_NEG  = 4'd5;
  localparam logic [3:0] S_DADD = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_ADDB = 4'd8;

  logic [3:0]             state;
  logic [CW-1:0]          cnt;
  logic [SHW-1:0]         sh;
  logic                   ph;
  logic [KEY_W-1:0]       r;
  logic [KEY_W-1:0]       opnd;
  logic [KEY_W-1:0]       a_red;
  logic [KEY_W-1:0]       b_red;
  logic [KEY_W-1:0]       x_red;
  logic [KEY_W-1:0]       inv;
  logic [KEY_W-1:0]       t;
  logic                   key_valid;
  logic                   key_err;
  logic [SYMBOL_BITS-1:0] xin;

  logic [UNIT_W-1:0]      ua;
  logic [UNIT_W-1:0]      ub;
  logic                   ucin;
  logic [UNIT_W-1:0]      usum;
  logic [KEY_W-1:0]       u8;
  logic                   msb;
  logic [KEY_W-1:0]       m_less1;

  assign u8      = usum[KEY_W-1:0];
  assign msb     = sh[SHW-1];
  assign m_less1 = cfg.modulus - KEY_W'(1);
  assign busy    = (state != S_IDLE);

  // Operand select for the shared modular adder
  always_comb begin
    ua   = UNIT_W'(r);
    ub   = UNIT_W'(r);
    ucin = 1'b0;
    case (state)
      S_ARED, S_BRED, S_XRED: begin
        ucin = msb;
      end
      S_INV: begin
        ub = UNIT_W'(a_red);
      end
      S_NEG: begin
        ua   = UNIT_W'(cfg.modulus);
        ub   = ~UNIT_W'(b_red);
        ucin = 1'b1;
      end
      S_DADD: begin
        ua = UNIT_W'(x_red);
      end
      S_MUL: begin
        if (ph) begin
          ub = UNIT_W'(opnd);
        end
      end
      S_ADDB: begin
        ub = UNIT_W'(b_red);
      end
      default: begin
        ua = UNIT_W'(r);
      end
    endcase
  end

  acm_modadd u_modadd (
    .a       (ua),
    .b       (ub),
    .cin     (ucin),
    .modulus (cfg.modulus),
    .sum     (usum)
  );

  // Control and datapath sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_valid <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      res.valid <= 1'b0;
      if (key_flush) begin
        key_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            xin <= symbol_in;
            r   <= '0;
            cnt <= CW'(KEY_W);
            if (cfg.modulus == '0 || (key_valid && key_err)) begin
              res.valid <= 1'b1;
              res.sym   <= '0;
              res.err   <= 1'b1;
            end else if (key_valid) begin
              sh    <= SHW'(cfg.offset) << (SHW - KEY_W);
              state <= S_BRED;
            end else begin
              sh    <= SHW'(cfg.multiplier) << (SHW - KEY_W);
              state <= S_ARED;
            end
          end
        end
        // Bit-serial reduction of the multiplier; r then seeds the search
        S_ARED: begin
          r   <= u8;
          sh  <= sh << 1;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            a_red <= u8;
            t     <= KEY_W'(1);
            state <= S_INV;
          end
        end
        // Inverse search: r holds t*a mod m
        S_INV: begin
          if (cfg.modulus == KEY_W'(1) || r == KEY_W'(1)) begin
            inv       <= (cfg.modulus == KEY_W'(1)) ? '0 : t;
            key_valid <= 1'b1;
            key_err   <= 1'b0;
            sh        <= SHW'(cfg.offset) << (SHW - KEY_W);
            cnt       <= CW'(KEY_W);
            r         <= '0;
            state     <= S_BRED;
          end else if (t == m_less1) begin
            key_valid <= 1'b1;
            key_err   <= 1'b1;
            res.valid <= 1'b1;
            res.sym   <= '0;
            res.err   <= 1'b1;
            state     <= S_IDLE;
          end else begin
            r <= u8;
            t <= t + KEY_W'(1);
          end
        end
        S_BRED: begin
          r   <= u8;
          sh  <= sh << 1;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            b_red <= u8;
            sh    <= SHW'(xin) << (SHW - SYMBOL_BITS);
            cnt   <= CW'(SYMBOL_BITS);
            r     <= '0;
            state <= S_XRED;
          end
        end
        S_XRED: begin
          r   <= u8;
          sh  <= sh << 1;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            x_red <= u8;
            if (cfg.decrypt_mode) begin
              state <= S_NEG;
            end else begin
              opnd  <= u8;
              sh    <= SHW'(a_red) << (SHW - KEY_W);
              cnt   <= CW'(KEY_W);
              r     <= '0;
              ph    <= 1'b0;
              state <= S_MUL;
            end
          end
        end
        // r = (m - b) mod m
        S_NEG: begin
          r     <= u8;
          state <= S_DADD;
        end
        // operand = (x - b) mod m, then multiply by the inverse
        S_DADD: begin
          opnd  <= u8;
          sh    <= SHW'(inv) << (SHW - KEY_W);
          cnt   <= CW'(KEY_W);
          r     <= '0;
          ph    <= 1'b0;
          state <= S_MUL;
        end
        // MSB-first double and add, one half-step per cycle
        S_MUL: begin
          if (!ph) begin
            r  <= u8;
            ph <= 1'b1;
          end else begin
            if (msb) begin
              r <= u8;
            end
            sh  <= sh << 1;
            cnt <= cnt - CW'(1);
            ph  <= 1'b0;
            if (cnt == CW'(1)) begin
              if (cfg.decrypt_mode) begin
                res.valid <= 1'b1;
                res.sym   <= msb ? u8 : r;
                res.err   <= 1'b0;
                state     <= S_IDLE;
              end else begin
                state <= S_ADDB;
              end
            end
          end
        end
        S_ADDB: begin
          res.valid <= 1'b1;
          res.sym   <= u8;
          res.err   <= 1'b0;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_affine_cipher_mod_m_core.sv
// Self-checking testbench for the affine cipher core: directed table, then random key phases.
module tb_affine_cipher_mod_m_core;
  import acm_pkg::*;

  localparam int SYMBOL_BITS = 8;
  localparam int RANDOM_ITEMS = 1100;
  localparam int SETTLE_CYCLES = 320;       // worst symbol: full inverse search plus the rest of the sequence
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int DIR_COUNT = 23;

  // One result of the core
  typedef struct packed {
    logic [SYMBOL_BITS-1:0] sym;
    logic                   err;
  } cipher_result_t;

  // One directed row: key setting, symbol, and an optional hand-written answer
  typedef struct packed {
    logic [KEY_W-1:0]       m;
    logic [KEY_W-1:0]       a;
    logic [KEY_W-1:0]       b;
    logic                   dec;
    logic [SYMBOL_BITS-1:0] sym;
    logic                   fixed;
    logic [SYMBOL_BITS-1:0] want_sym;
    logic                   want_err;
  } dir_vec_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [SYMBOL_BITS-1:0] symbol_in = '0;
  logic                   done;
  logic [SYMBOL_BITS-1:0] symbol_out;
  logic                   key_error;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = REG_MODULUS;
  logic [KEY_W-1:0]       cfg_data = '0;

  // Local copy of the key registers, tracking every write transfer
  logic [KEY_W-1:0] key_m = 8'd26;
  logic [KEY_W-1:0] key_a = 8'd1;
  logic [KEY_W-1:0] key_b = 8'd0;
  logic             key_dec = 1'b0;

  cipher_result_t due_results[$];
  cipher_result_t oldest_due;
  int mismatches = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  dir_vec_t directed_vecs [DIR_COUNT] = '{
    // reset keys: identity over 26 symbols, wide symbol reduced
    '{26, 1, 0, 0, 0, 1, 0, 0},
    '{26, 1, 0, 0, 25, 1, 25, 0},
    '{26, 1, 0, 0, 255, 1, 21, 0},
    // classic key, both directions
    '{26, 5, 8, 0, 7, 0, 0, 0},
    '{26, 5, 8, 1, 17, 0, 0, 0},
    '{26, 5, 8, 1, 255, 0, 0, 0},
    // multiplier sharing a factor with m, and multiplier zero
    '{26, 13, 8, 0, 3, 1, 0, 1},
    '{26, 0, 8, 1, 3, 1, 0, 1},
    // modulus zero: always a key error
    '{0, 1, 0, 0, 5, 1, 0, 1},
    '{0, 1, 0, 1, 255, 1, 0, 1},
    // modulus one: everything collapses to symbol 0
    '{1, 0, 200, 0, 200, 1, 0, 0},
    '{1, 0, 200, 1, 255, 1, 0, 0},
    // largest modulus, keys just below and at m
    '{255, 254, 255, 0, 255, 0, 0, 0},
    '{255, 254, 255, 1, 254, 0, 0, 0},
    '{255, 255, 0, 0, 1, 1, 0, 1},
    // smallest useful modulus, then assorted keys
    '{2, 1, 1, 0, 1, 0, 0, 0},
    '{2, 3, 255, 1, 0, 0, 0, 0},
    '{251, 200, 100, 1, 250, 0, 0, 0},
    '{128, 127, 0, 1, 128, 0, 0, 0},
    '{128, 64, 0, 1, 9, 1, 0, 1},
    '{97, 255, 0, 0, 170, 0, 0, 0},
    '{200, 199, 137, 1, 85, 0, 0, 0},
    '{26, 3, 25, 0, 25, 0, 0, 0}
  };

  affine_cipher_mod_m_core #(
    .SYMBOL_BITS(SYMBOL_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .symbol_in (symbol_in),
    .done      (done),
    .symbol_out(symbol_out),
    .key_error (key_error),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Inverse of a modulo m by extended Euclid; -1 when gcd(a, m) != 1
  function automatic int key_inverse(input int a, input int m);
    int r0, r1, r2, t0, t1, t2, q;
    r0 = m;
    r1 = a % m;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      t2 = t0 - q * t1;
      r0 = r1;
      r1 = r2;
      t0 = t1;
      t1 = t2;
    end
    if (r0 != 1) return -1;
    t0 = t0 % m;
    if (t0 < 0) t0 += m;
    return t0;
  endfunction

  // Expected result for one symbol under the current keys
  function automatic cipher_result_t affine_map(input logic [SYMBOL_BITS-1:0] sym);
    cipher_result_t r;
    int m, inv, x, y;
    r = '0;
    m = key_m;
    if (m == 0) begin
      r.err = 1'b1;
      return r;
    end
    inv = key_inverse(key_a, m);
    if (inv < 0) begin
      r.err = 1'b1;
      return r;
    end
    x = sym % m;
    if (!key_dec) y = ((key_a % m) * x + key_b % m) % m;
    else y = (inv * ((x + m - key_b % m) % m)) % m;
    r.sym = y[SYMBOL_BITS-1:0];
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none at all in a no-idle phase
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one symbol and wait for its transfer; start stays high for a back-to-back item
  task automatic push_symbol(input logic [SYMBOL_BITS-1:0] sym, input cipher_result_t want);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    symbol_in <= sym;
    do @(posedge clk); while (busy);
    due_results.push_back(want);
  endtask

  // Stop sending and wait until every expected result has arrived
  task automatic hold_until_idle();
    start <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0 || busy);
  endtask

  // One register write transfer; valid is left high for a back-to-back write
  task automatic write_reg(input logic [1:0] idx, input logic [KEY_W-1:0] data);
    int gap;
    gap = (no_idle || $urandom_range(0, 1)) ? 0 : $urandom_range(1, 4);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODULUS:    key_m = data;
      REG_MULTIPLIER: key_a = data;
      REG_OFFSET:     key_b = data;
      REG_DECRYPT:    key_dec = data[0];
      default: ;
    endcase
  endtask

  // Bring the block to idle, then write registers that change (or all, on refresh)
  task automatic load_keys(input logic [KEY_W-1:0] m, input logic [KEY_W-1:0] a,
                           input logic [KEY_W-1:0] b, input logic dec, input bit refresh);
    hold_until_idle();
    if (refresh || m != key_m) write_reg(REG_MODULUS, m);
    if (refresh || a != key_a) write_reg(REG_MULTIPLIER, a);
    if (refresh || b != key_b) write_reg(REG_OFFSET, b);
    if (refresh || dec != key_dec) write_reg(REG_DECRYPT, {{(KEY_W-1){1'b0}}, dec});
    cfg_valid <= 1'b0;
  endtask

  // Result checker: each done strobe is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: symbol_out %0d key_error %0b",
                 $time, symbol_out, key_error);
      end else begin
        oldest_due = due_results.pop_front();
        if (symbol_out !== oldest_due.sym) begin
          mismatches++;
          $display("%0t: symbol_out expected %0d, got %0d", $time, oldest_due.sym, symbol_out);
        end
        if (key_error !== oldest_due.err) begin
          mismatches++;
          $display("%0t: key_error expected %0b, got %0b", $time, oldest_due.err, key_error);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
      $display("affine_cipher_mod_m_core verification failed");
      $finish;
    end
  end

  initial begin
    int issued;
    int phase_len;
    logic [KEY_W-1:0] m, a, b;
    logic dec;
    logic [SYMBOL_BITS-1:0] sym;
    cipher_result_t want;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < DIR_COUNT; i++) begin
      load_keys(directed_vecs[i].m, directed_vecs[i].a, directed_vecs[i].b,
                directed_vecs[i].dec, 1'b0);
      if (directed_vecs[i].fixed) want = '{directed_vecs[i].want_sym, directed_vecs[i].want_err};
      else want = affine_map(directed_vecs[i].sym);
      push_symbol(directed_vecs[i].sym, want);
    end

    // Random phases: mostly invertible keys, some bad keys and extreme moduli
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      m = key_m;
      a = key_a;
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 19))
          0:       m = 8'd0;
          1:       m = 8'd1;
          2:       m = 8'd2;
          3:       m = 8'd255;
          default: m = KEY_W'($urandom_range(3, 254));
        endcase
        a = KEY_W'($urandom_range(0, 255));
        if (m > 1 && $urandom_range(0, 4) != 0)
          while (key_inverse(a, m) < 0) a = KEY_W'($urandom_range(1, 255));
      end
      b = KEY_W'($urandom_range(0, 255));
      dec = 1'($urandom_range(0, 1));
      load_keys(m, a, b, dec, $urandom_range(0, 3) == 0);
      no_idle = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(10, 50);
      for (int k = 0; k < phase_len; k++) begin
        if (key_m > 1 && $urandom_range(0, 1)) sym = SYMBOL_BITS'($urandom_range(0, key_m - 1));
        else sym = SYMBOL_BITS'($urandom_range(0, 255));
        push_symbol(sym, affine_map(sym));
        issued++;
      end
      no_idle = 1'b0;
    end

    // Drain, then let any stray strobe show up
    hold_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end
    if (mismatches == 0) begin
      $display("affine_cipher_mod_m_core verification clean");
    end else begin
      $display("affine_cipher_mod_m_core verification failed");
    end
    $finish;
  end

endmodule
